### src/cubemap_to_equirect_address_assert.svh
// Assertion macros shared by the address block.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef CUBEMAP_TO_EQUIRECT_ADDRESS_ASSERT_SVH
`define CUBEMAP_TO_EQUIRECT_ADDRESS_ASSERT_SVH
`define CEQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### src/ceq_pkg.sv
// Types, constants and the arctangent table of the cube-face address block.
// No dependencies.
package ceq_pkg;

	localparam int FACE_BITS         = 12;
	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int XW                = 21;
	localparam int ZW                = 34;
	localparam int QW                = 17;
	localparam int REMW              = 13;
	localparam int ATAN_LEN          = 24;

	localparam logic [2:0] FACE_FRONT  = 3'd0;
	localparam logic [2:0] FACE_RIGHT  = 3'd1;
	localparam logic [2:0] FACE_LEFT   = 3'd2;
	localparam logic [2:0] FACE_REAR   = 3'd3;
	localparam logic [2:0] FACE_BOTTOM = 3'd4;
	localparam logic [2:0] FACE_TOP    = 3'd5;

	localparam logic [1:0] REG_FACE_SIZE   = 2'd0;
	localparam logic [1:0] REG_PANO_WIDTH  = 2'd1;
	localparam logic [1:0] REG_PANO_HEIGHT = 2'd2;

	localparam logic [12:0] FACE_SIZE_RST   = 13'd512;
	localparam logic [14:0] PANO_WIDTH_RST  = 15'd2048;
	localparam logic [13:0] PANO_HEIGHT_RST = 14'd1024;

	localparam logic signed [XW-1:0] ONE_Q16 = XW'(65536);
	localparam logic signed [ZW-1:0] ANG_PI  = ZW'(64'd1073741824);
	localparam logic [15:0] INV_GAIN_Q16     = 16'd39797;

	localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
		32'd268435456, 32'd158466703, 32'd83729454, 32'd42502378, 32'd21333666,
		32'd10677233, 32'd5339919, 32'd2670123, 32'd1335082, 32'd667543,
		32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861, 32'd10430,
		32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41
	};

	typedef struct packed {
		logic [2:0]           face;
		logic [FACE_BITS-1:0] face_x;
		logic [FACE_BITS-1:0] face_y;
	} ceq_req_t;

	typedef struct packed {
		logic [13:0] src_col;
		logic [12:0] src_row;
		logic [26:0] src_addr;
	} ceq_res_t;

	typedef struct packed {
		logic [REMW-1:0] rem;
		logic [QW-1:0]   quo;
	} ceq_div_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} ceq_vec_t;

	function automatic logic signed [ZW-1:0] ceq_atan(input int idx);
		ceq_atan = $signed({2'b00, ATAN_TAB[idx]});
	endfunction

endpackage

### src/ceq_delay.sv
// Shift line that carries side data and a valid bit alongside a pipeline.
// No dependencies.
module ceq_delay #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] line_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) line_q[k] <= '0;
		end else begin
			line_q[0] <= din;
			for (int k = 1; k < N; k++) line_q[k] <= line_q[k-1];
		end
	end

	assign dout = line_q[N-1];
endmodule

### src/ceq_div_cell.sv
// One restoring division step: one quotient bit per cell.
// Depends on ceq_pkg.
module ceq_div_cell (
	input  logic                   clk,
	input  logic [12:0]            fs,
	input  ceq_pkg::ceq_div_t      din,
	output ceq_pkg::ceq_div_t      dout
);
	import ceq_pkg::*;

	logic [REMW:0] dbl;
	logic          take;

	always_comb begin
		dbl  = {din.rem, 1'b0};
		take = dbl >= {1'b0, fs};
	end

	always_ff @(posedge clk) begin
		dout.rem <= take ? REMW'(dbl - {1'b0, fs}) : dbl[REMW-1:0];
		dout.quo <= {din.quo[QW-2:0], take};
	end
endmodule

### src/ceq_cordic_cell.sv
// One vectoring rotation of the arctangent chain, fixed shift per cell.
// Depends on ceq_pkg.
module ceq_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  ceq_pkg::ceq_vec_t din,
	output ceq_pkg::ceq_vec_t dout
);
	import ceq_pkg::*;

	localparam logic signed [ZW-1:0] ANG = ceq_atan(IDX);

	logic signed [XW-1:0] xs, ys;
	logic                 ypos, yneg;

	always_comb begin
		xs   = din.x >>> IDX;
		ys   = din.y >>> IDX;
		yneg = din.y[XW-1];
		ypos = !yneg && (din.y != '0);
	end

	always_ff @(posedge clk) begin
		if (ypos) begin
			dout.x <= din.x + ys;
			dout.y <= din.y - xs;
			dout.z <= din.z + ANG;
		end else if (yneg) begin
			dout.x <= din.x - ys;
			dout.y <= din.y + xs;
			dout.z <= din.z - ANG;
		end else begin
			dout <= din;
		end
	end
endmodule

### src/ceq_cordic.sv
// Vectoring arctangent: a half-plane fold followed by a row of rotation cells.
// Depends on ceq_pkg and ceq_cordic_cell.
module ceq_cordic #(
	parameter int STEPS = ceq_pkg::CORDIC_STEPS_DEF
) (
	input  logic                           clk,
	input  logic signed [ceq_pkg::XW-1:0]  x,
	input  logic signed [ceq_pkg::XW-1:0]  y,
	output ceq_pkg::ceq_vec_t              dout
);
	import ceq_pkg::*;

	ceq_vec_t chain [STEPS+1];

	always_ff @(posedge clk) begin
		if (x[XW-1]) begin
			chain[0].x <= -x;
			chain[0].y <= -y;
			chain[0].z <= y[XW-1] ? -ANG_PI : ANG_PI;
		end else begin
			chain[0].x <= x;
			chain[0].y <= y;
			chain[0].z <= '0;
		end
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_cell
		ceq_cordic_cell #(.IDX(g)) u_cell (
			.clk  (clk),
			.din  (chain[g]),
			.dout (chain[g+1])
		);
	end

	assign dout = chain[STEPS];
endmodule

### src/cubemap_to_equirect_address.sv
// Cube-face pixel to equirectangular source address, fully pipelined.
// Its depth is set by the two division chains of 17 cells and the two
// rotation chains of CORDIC_STEPS cells each.
// One request is taken every cycle; busy stays low and results cannot stall.
// Reset clears the valid pipeline and loads the register defaults.
`include "cubemap_to_equirect_address_assert.svh"
module cubemap_to_equirect_address #(
	parameter int CORDIC_STEPS = ceq_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  ceq_pkg::ceq_req_t req,
	output logic              done,
	output ceq_pkg::ceq_res_t result
);
	import ceq_pkg::*;

	logic [12:0] face_size_q;
	logic [14:0] pano_width_q;
	logic [13:0] pano_height_q;
	logic [12:0] fs_eff;
	logic [14:0] w_eff;
	logic [13:0] h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_size_q   <= FACE_SIZE_RST;
			pano_width_q  <= PANO_WIDTH_RST;
			pano_height_q <= PANO_HEIGHT_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_FACE_SIZE:   face_size_q   <= pwdata[12:0];
				REG_PANO_WIDTH:  pano_width_q  <= pwdata[14:0];
				REG_PANO_HEIGHT: pano_height_q <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FACE_SIZE:   prdata = {19'd0, face_size_q};
			REG_PANO_WIDTH:  prdata = {17'd0, pano_width_q};
			REG_PANO_HEIGHT: prdata = {18'd0, pano_height_q};
			default:         prdata = '0;
		endcase
		fs_eff = (face_size_q == '0) ? 13'd1 : face_size_q;
		if (pano_width_q == '0)         w_eff = 15'd1;
		else if (pano_width_q > 15'd16384) w_eff = 15'd16384;
		else                            w_eff = pano_width_q;
		if (pano_height_q == '0)        h_eff = 14'd1;
		else if (pano_height_q > 14'd8192) h_eff = 14'd8192;
		else                            h_eff = pano_height_q;
	end

	assign pready = 1'b1;
	assign busy   = 1'b0;

	// Stage 1: range check of the face coordinates.
	logic       vld_s1;
	logic [2:0] face_s1;
	logic       sat_u_s1, sat_v_s1;
	ceq_div_t   div_u [QW+1];
	ceq_div_t   div_v [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		face_s1      <= req.face;
		sat_u_s1     <= {1'b0, req.face_x} >= fs_eff;
		sat_v_s1     <= {1'b0, req.face_y} >= fs_eff;
		div_u[0].rem <= ({1'b0, req.face_x} >= fs_eff) ? '0 : REMW'(req.face_x);
		div_v[0].rem <= ({1'b0, req.face_y} >= fs_eff) ? '0 : REMW'(req.face_y);
		div_u[0].quo <= '0;
		div_v[0].quo <= '0;
	end

	for (genvar g = 0; g < QW; g++) begin : g_div
		ceq_div_cell u_div_u (.clk(clk), .fs(fs_eff), .din(div_u[g]), .dout(div_u[g+1]));
		ceq_div_cell u_div_v (.clk(clk), .fs(fs_eff), .din(div_v[g]), .dout(div_v[g+1]));
	end

	logic [5:0] side_d1;
	ceq_delay #(.W(6), .N(QW)) u_dly_div (
		.clk(clk), .arst_n(arst_n), .din({vld_s1, sat_u_s1, sat_v_s1, face_s1}), .dout(side_d1)
	);

	// Stage 2: face direction vector.
	logic                 vld_s2;
	logic signed [XW-1:0] dx_s2, dy_s2, dz_s2;
	logic signed [XW-1:0] u_c, v_c;

	always_comb begin
		u_c = side_d1[4] ? ONE_Q16 : $signed({{(XW-QW){1'b0}}, div_u[QW].quo}) - ONE_Q16;
		v_c = side_d1[3] ? ONE_Q16 : $signed({{(XW-QW){1'b0}}, div_v[QW].quo}) - ONE_Q16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= side_d1[5];
	end

	always_ff @(posedge clk) begin
		case (side_d1[2:0])
			FACE_FRONT:  begin dx_s2 <= ONE_Q16;  dy_s2 <= u_c;      dz_s2 <= -v_c;     end
			FACE_RIGHT:  begin dx_s2 <= -u_c;     dy_s2 <= ONE_Q16;  dz_s2 <= -v_c;     end
			FACE_LEFT:   begin dx_s2 <= u_c;      dy_s2 <= -ONE_Q16; dz_s2 <= -v_c;     end
			FACE_REAR:   begin dx_s2 <= -ONE_Q16; dy_s2 <= -u_c;     dz_s2 <= -v_c;     end
			FACE_BOTTOM: begin dx_s2 <= -v_c;     dy_s2 <= u_c;      dz_s2 <= -ONE_Q16; end
			FACE_TOP:    begin dx_s2 <= v_c;      dy_s2 <= u_c;      dz_s2 <= ONE_Q16;  end
			default:     begin dx_s2 <= '0;       dy_s2 <= '0;       dz_s2 <= '0;       end
		endcase
	end

	ceq_vec_t lon;
	ceq_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_lon (
		.clk(clk), .x(dx_s2), .y(dy_s2), .dout(lon)
	);

	logic [XW:0] side_d2;
	ceq_delay #(.W(XW+1), .N(CORDIC_STEPS+1)) u_dly_lon (
		.clk(clk), .arst_n(arst_n), .din({vld_s2, dz_s2}), .dout(side_d2)
	);

	// Stage 3: gain removal from the horizontal magnitude.
	logic                 vld_s3;
	logic signed [XW-1:0] r_s3, dz_s3;
	logic signed [ZW-1:0] theta_s3;
	logic [35:0]          rprod;

	assign rprod = lon.x[19:0] * INV_GAIN_Q16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= side_d2[XW];
	end

	always_ff @(posedge clk) begin
		r_s3     <= $signed({1'b0, rprod[35:16]});
		dz_s3    <= side_d2[XW-1:0];
		theta_s3 <= lon.z;
	end

	ceq_vec_t lat;
	ceq_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_lat (
		.clk(clk), .x(dz_s3), .y(r_s3), .dout(lat)
	);

	logic [ZW:0] side_d3;
	ceq_delay #(.W(ZW+1), .N(CORDIC_STEPS+1)) u_dly_lat (
		.clk(clk), .arst_n(arst_n), .din({vld_s3, theta_s3}), .dout(side_d3)
	);

	// Stage 4: angle offset and range flags.
	logic                 vld_s4, tz_s4, tbig_s4, pz_s4, pbig_s4;
	logic [30:0]          t_s4;
	logic [29:0]          p_s4;
	logic signed [ZW-1:0] t_c;

	assign t_c = $signed(side_d3[ZW-1:0]) + ANG_PI;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= side_d3[ZW];
	end

	always_ff @(posedge clk) begin
		tz_s4   <= t_c[ZW-1];
		tbig_s4 <= !t_c[ZW-1] && (t_c[ZW-2:31] != '0);
		t_s4    <= t_c[30:0];
		pz_s4   <= lat.z[ZW-1];
		pbig_s4 <= !lat.z[ZW-1] && (lat.z[ZW-2:30] != '0);
		p_s4    <= lat.z[29:0];
	end

	// Stage 5: scaling to the panorama size.
	logic        vld_s5, tz_s5, tbig_s5, pz_s5, pbig_s5;
	logic [45:0] cprod_s5;
	logic [43:0] rprod_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else         vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		tz_s5    <= tz_s4;
		tbig_s5  <= tbig_s4;
		pz_s5    <= pz_s4;
		pbig_s5  <= pbig_s4;
		cprod_s5 <= t_s4 * w_eff;
		rprod_s5 <= p_s4 * h_eff;
	end

	// Stage 6: clamping to the image.
	logic        vld_s6;
	logic [13:0] col_s6;
	logic [12:0] row_s6;
	logic [14:0] cmax;
	logic [13:0] rmax;

	assign cmax = w_eff - 15'd1;
	assign rmax = h_eff - 14'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else         vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (tz_s5)                                   col_s6 <= '0;
		else if (tbig_s5 || cprod_s5[45:31] > cmax)  col_s6 <= cmax[13:0];
		else                                         col_s6 <= cprod_s5[44:31];
		if (pz_s5)                                   row_s6 <= '0;
		else if (pbig_s5 || rprod_s5[43:30] > rmax)  row_s6 <= rmax[12:0];
		else                                         row_s6 <= rprod_s5[42:30];
	end

	// Stage 7: linear address and result register.
	logic        vld_s7;
	logic [27:0] aprod;

	assign aprod = row_s6 * w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else         vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		result.src_col  <= col_s6;
		result.src_row  <= row_s6;
		result.src_addr <= 27'(aprod + {14'd0, col_s6});
	end

	assign done = vld_s7;

	`CEQ_ASSERT_NEXT(a_accept_enters, start && !busy, vld_s1, "Accepted request missing from stage one.")
	`CEQ_ASSERT_NOW(a_done_follows, done, $past(vld_s6), "Result strobe without a clamped value.")
	`CEQ_ASSERT_NEXT(a_row_floor, vld_s5 && pz_s5, row_s6 == '0, "Negative polar angle not clamped.")
endmodule

### dv/cubemap_to_equirect_address_test.sv
// Self-checking testbench of the cube-face to equirectangular address block.
// Depends on ceq_pkg and cubemap_to_equirect_address; predicts each result
// with a behavioural CORDIC and compares it against the done strobe.
`timescale 1ns / 1ps
module cubemap_to_equirect_address_test;
	import ceq_pkg::*;

	localparam int LATENCY = 26 + 2 * CORDIC_STEPS_DEF;
	localparam int N_RANDOM = 430;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	ceq_req_t req = '0;
	logic done;
	ceq_res_t result;

	cubemap_to_equirect_address u_top (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .req(req), .done(done), .result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("== FAIL ==");
		$finish;
	end

	logic [12:0] cur_face_size;
	logic [14:0] cur_pano_width;
	logic [13:0] cur_pano_height;
	ceq_res_t expected_addrs[$];
	int n_errors = 0;
	int n_checked = 0;
	int n_requests = 0;
	int n_settings = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	function automatic longint floor_shift(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint unit_coord(input longint coord, input longint size);
		longint q;
		q = (coord << 17) / size;
		if (q > 131072) q = 131072;
		return q - 65536;
	endfunction

	function automatic longint cordic_angle(input longint x, input longint y, output longint mag);
		longint z, xs, ys;
		z = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			return 0;
		end
		if (x < 0) begin
			z = (y >= 0) ? 64'sd1073741824 : -64'sd1073741824;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(y, i);
			if (y > 0) begin
				x += ys;
				y -= xs;
				z += longint'(ATAN_TAB[i]);
			end else if (y < 0) begin
				x -= ys;
				y += xs;
				z -= longint'(ATAN_TAB[i]);
			end
		end
		mag = x;
		return z;
	endfunction

	function automatic ceq_res_t source_address(input ceq_req_t r);
		longint fs, w, h, u, v, dx, dy, dz, theta, phi, mag, rad, t, col, row;
		ceq_res_t o;
		fs = cur_face_size ? cur_face_size : 1;
		w = cur_pano_width ? cur_pano_width : 1;
		h = cur_pano_height ? cur_pano_height : 1;
		if (w > 16384) w = 16384;
		if (h > 8192) h = 8192;
		u = unit_coord(r.face_x, fs);
		v = unit_coord(r.face_y, fs);
		theta = 0;
		phi = 0;
		dx = 0;
		dy = 0;
		dz = 0;
		case (r.face)
			FACE_FRONT: begin dx = 65536; dy = u; dz = -v; end
			FACE_RIGHT: begin dx = -u; dy = 65536; dz = -v; end
			FACE_LEFT: begin dx = u; dy = -65536; dz = -v; end
			FACE_REAR: begin dx = -65536; dy = -u; dz = -v; end
			FACE_BOTTOM: begin dx = -v; dy = u; dz = -65536; end
			FACE_TOP: begin dx = v; dy = u; dz = 65536; end
			default: ;
		endcase
		if (r.face <= FACE_TOP) begin
			theta = cordic_angle(dx, dy, mag);
			rad = (mag * 39797) >>> 16;
			phi = cordic_angle(dz, rad, mag);
		end
		t = theta + 64'sd1073741824;
		if (t < 0) t = 0;
		col = (t * w) >>> 31;
		if (col > w - 1) col = w - 1;
		if (phi < 0) phi = 0;
		row = (phi * h) >>> 30;
		if (row > h - 1) row = h - 1;
		o.src_col = col[13:0];
		o.src_row = row[12:0];
		o.src_addr = 27'(col + row * w);
		return o;
	endfunction

	always @(posedge clk) begin
		ceq_res_t want;
		if (arst_n && done) begin
			if (expected_addrs.size() == 0) begin
				report_mismatch("unexpected result", result.src_addr, -1);
			end else begin
				want = expected_addrs.pop_front();
				n_checked++;
				if (result.src_col !== want.src_col)
					report_mismatch("src_col", result.src_col, want.src_col);
				if (result.src_row !== want.src_row)
					report_mismatch("src_row", result.src_row, want.src_row);
				if (result.src_addr !== want.src_addr)
					report_mismatch("src_addr", result.src_addr, want.src_addr);
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FACE_SIZE: cur_face_size = value[12:0];
			REG_PANO_WIDTH: cur_pano_width = value[14:0];
			default: cur_pano_height = value[13:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		start <= 1'b0;
		while (expected_addrs.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic configure(input int fs, input int w, input int h);
		drain();
		write_reg(REG_FACE_SIZE, fs);
		write_reg(REG_PANO_WIDTH, w);
		write_reg(REG_PANO_HEIGHT, h);
		n_settings++;
	endtask

	task automatic send_request(input ceq_req_t r, input bit has_known, input ceq_res_t known);
		ceq_res_t pred;
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pred = source_address(r);
		if (has_known && pred !== known)
			report_mismatch("table entry", known.src_addr, pred.src_addr);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		expected_addrs.push_back(pred);
		n_requests++;
	endtask

	typedef struct {
		ceq_req_t r;
		bit has_known;
		ceq_res_t known;
	} stim_row_t;

	stim_row_t directed_rows[] = '{
		'{'{FACE_FRONT, 12'd256, 12'd256}, 1'b1, '{14'd1024, 13'd512, 27'd1049600}},
		'{'{3'd6, 12'd0, 12'd0}, 1'b1, '{14'd1024, 13'd0, 27'd1024}},
		'{'{3'd7, 12'hfff, 12'hfff}, 1'b1, '{14'd1024, 13'd0, 27'd1024}},
		'{'{FACE_FRONT, 12'd0, 12'd0}, 1'b0, '0},
		'{'{FACE_RIGHT, 12'd511, 12'd0}, 1'b0, '0},
		'{'{FACE_LEFT, 12'd0, 12'd511}, 1'b0, '0},
		'{'{FACE_REAR, 12'd256, 12'd256}, 1'b0, '0},
		'{'{FACE_REAR, 12'd0, 12'd100}, 1'b0, '0},
		'{'{FACE_BOTTOM, 12'd256, 12'd256}, 1'b0, '0},
		'{'{FACE_TOP, 12'd256, 12'd256}, 1'b0, '0},
		'{'{FACE_TOP, 12'd0, 12'd511}, 1'b0, '0},
		'{'{FACE_BOTTOM, 12'hfff, 12'hfff}, 1'b0, '0},
		'{'{FACE_FRONT, 12'hfff, 12'd0}, 1'b0, '0},
		'{'{FACE_RIGHT, 12'd1000, 12'd3000}, 1'b0, '0},
		'{'{FACE_REAR, 12'd256, 12'd0}, 1'b0, '0},
		'{'{FACE_LEFT, 12'd256, 12'd256}, 1'b0, '0}
	};

	task automatic random_requests(input int n);
		ceq_req_t r;
		int lim;
		lim = cur_face_size ? cur_face_size : 1;
		for (int k = 0; k < n; k++) begin
			r.face = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) :
				3'($urandom_range(0, 5));
			if ($urandom_range(0, 7) == 0) begin
				r.face_x = 12'($urandom());
				r.face_y = 12'($urandom());
			end else begin
				r.face_x = 12'($urandom_range(0, lim - 1));
				r.face_y = 12'($urandom_range(0, lim - 1));
			end
			send_request(r, 1'b0, '0);
		end
	endtask

	initial begin
		int settings[7][3];
		settings = '{
			'{1, 1, 1}, '{4096, 16384, 8192}, '{0, 0, 0}, '{8191, 32767, 16383},
			'{64, 360, 180}, '{4095, 16383, 8191}, '{512, 2048, 1024}
		};
		cur_face_size = FACE_SIZE_RST;
		cur_pano_width = PANO_WIDTH_RST;
		cur_pano_height = PANO_HEIGHT_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_request(directed_rows[i].r, directed_rows[i].has_known, directed_rows[i].known);
		for (int s = 0; s < 7; s++) begin
			configure(settings[s][0], settings[s][1], settings[s][2]);
			random_requests(N_RANDOM / 10);
		end
		configure($urandom_range(1, 4096), $urandom_range(1, 16384), $urandom_range(1, 8192));
		random_requests(N_RANDOM - 7 * (N_RANDOM / 10));
		drain();
		$display("Checked %0d of %0d requests over %0d register settings.",
			n_checked, n_requests, n_settings + 1);
		$display("Covered all six faces, unknown faces, off-face pixels and size extremes.");
		if (n_errors == 0 && expected_addrs.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
